// File: rtl/gkc_pkg.sv
// ----------------------------------------------------------------------------
// gkc_pkg
// shared constants, types and state encoding of the greedy k-center unit
// ----------------------------------------------------------------------------
`default_nettype none

package gkc_pkg;

    localparam int MAX_POINTS  = 32;
    localparam int MAX_CENTERS = 32;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 6;
    localparam int COORD_W     = 16;
    localparam int DIST_W      = 33;
    localparam int PROD_W      = 32;
    localparam int LBL_W       = 5;
    localparam int CFG_W       = 6;

    localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};
    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(1);

    localparam logic KIND_CENTER = 1'b0;
    localparam logic KIND_POINT  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PICK0_RD,
        ST_PICK0_CAP,
        ST_CENTER,
        ST_RD,
        ST_SQX,
        ST_SQY,
        ST_UPD,
        ST_OUT_RD,
        ST_OUT_EMIT
    } t_state;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             pt_we;
        logic [IDX_W-1:0] pt_addr;
        logic             d_we;
    } t_store_ctl;

    typedef struct packed {
        logic sq_en;
        logic acc_load;
    } t_dist_ctl;

endpackage

`default_nettype wire

// File: rtl/greedy_k_center_clustering_unit.sv
// ----------------------------------------------------------------------------
// greedy_k_center_clustering_unit
// farthest-point k-center selection over up to 32 loaded 2-D points
// ----------------------------------------------------------------------------
// loading: one point per cycle, busy stays low between non-final points
// run (n points, k centers): busy high; each point visit steps through read,
//   square x, square y and update states, using the one shared squarer
// results: center items then point items, one cycle each, no stall possible
// reset: synchronous active low; clears control, point count, configured k back to 1
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_k_center_clustering_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output      logic                                busy,
    input  wire logic signed [gkc_pkg::COORD_W-1:0]  i_point_x,
    input  wire logic signed [gkc_pkg::COORD_W-1:0]  i_point_y,
    input  wire logic                                i_final_point,
    input  wire logic                                i_cfg_we,
    input  wire logic        [gkc_pkg::CFG_W-1:0]    i_cfg_data,
    output      logic                                o_result_valid,
    output      logic                                o_item_kind,
    output      logic        [gkc_pkg::IDX_W-1:0]    o_item_index,
    output      logic signed [gkc_pkg::COORD_W-1:0]  o_coord_x,
    output      logic signed [gkc_pkg::COORD_W-1:0]  o_coord_y,
    output      logic        [gkc_pkg::LBL_W-1:0]    o_cluster_label,
    output      logic        [gkc_pkg::DIST_W-1:0]   o_squared_distance,
    output      logic                                o_run_end
);

    gkc_pkg::t_state    r_state, n_state;
    gkc_pkg::t_store_ctl store_ctl;
    gkc_pkg::t_dist_ctl  dist_ctl;

    logic [gkc_pkg::CFG_W-1:0] r_cfg;
    logic [gkc_pkg::CNT_W-1:0] r_count, n_count;
    logic [gkc_pkg::CNT_W-1:0] r_n, n_n;
    logic [gkc_pkg::CNT_W-1:0] r_k, n_k;
    logic [gkc_pkg::CNT_W-1:0] r_round, n_round;
    logic [gkc_pkg::CNT_W-1:0] r_j, n_j;

    logic signed [gkc_pkg::COORD_W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [gkc_pkg::COORD_W-1:0] r_cand_x, n_cand_x, r_cand_y, n_cand_y;
    logic        [gkc_pkg::DIST_W-1:0]  r_max, n_max;

    logic signed [gkc_pkg::COORD_W-1:0] rd_x, rd_y;
    logic        [gkc_pkg::DIST_W-1:0]  rd_dist;
    logic        [gkc_pkg::LBL_W-1:0]   rd_label;
    logic signed [gkc_pkg::COORD_W-1:0] sq_a, sq_b;
    logic        [gkc_pkg::DIST_W-1:0]  sum;
    logic        [gkc_pkg::DIST_W-1:0]  old_dist, new_dist;
    logic                               closer;
    logic                               accept;

    logic                               n_valid;
    logic                               n_kind;
    logic        [gkc_pkg::IDX_W-1:0]   n_index;
    logic signed [gkc_pkg::COORD_W-1:0] n_ox, n_oy;
    logic        [gkc_pkg::LBL_W-1:0]   n_label;
    logic        [gkc_pkg::DIST_W-1:0]  n_dist;
    logic                               n_end;

    gkc_store u_store (
        .i_clk      (i_clk),
        .i_ctl      (store_ctl),
        .i_pt_x     (i_point_x),
        .i_pt_y     (i_point_y),
        .i_dist     (new_dist),
        .i_label    (r_round[gkc_pkg::LBL_W-1:0]),
        .o_rd_x     (rd_x),
        .o_rd_y     (rd_y),
        .o_rd_dist  (rd_dist),
        .o_rd_label (rd_label)
    );

    gkc_dist_unit u_dist (
        .i_clk (i_clk),
        .i_ctl (dist_ctl),
        .i_a   (sq_a),
        .i_b   (sq_b),
        .o_sum (sum)
    );

    assign busy   = (r_state != gkc_pkg::ST_IDLE);
    assign accept = start && !busy;

    // first round sees every distance as the sentinel
    assign old_dist = (r_round == '0) ? gkc_pkg::DIST_ONES : rd_dist;
    assign closer   = (sum < old_dist);
    assign new_dist = closer ? sum : old_dist;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_n       = r_n;
        n_k       = r_k;
        n_round   = r_round;
        n_j       = r_j;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_cand_x  = r_cand_x;
        n_cand_y  = r_cand_y;
        n_max     = r_max;

        store_ctl.rd_en   = 1'b0;
        store_ctl.rd_addr = r_j[gkc_pkg::IDX_W-1:0];
        store_ctl.pt_we   = 1'b0;
        store_ctl.pt_addr = r_count[gkc_pkg::IDX_W-1:0];
        store_ctl.d_we    = 1'b0;
        dist_ctl.sq_en    = 1'b0;
        dist_ctl.acc_load = 1'b0;
        sq_a              = r_cx;
        sq_b              = rd_x;

        n_valid = 1'b0;
        n_kind  = gkc_pkg::KIND_CENTER;
        n_index = r_round[gkc_pkg::IDX_W-1:0];
        n_ox    = r_cand_x;
        n_oy    = r_cand_y;
        n_label = '0;
        n_dist  = '0;
        n_end   = 1'b0;

        unique case (r_state)
            gkc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (r_count < gkc_pkg::CNT_W'(gkc_pkg::MAX_POINTS)) begin
                        store_ctl.pt_we = 1'b1;
                        n_count         = r_count + 1'b1;
                    end
                    if (i_final_point) begin
                        n_n = (r_count < gkc_pkg::CNT_W'(gkc_pkg::MAX_POINTS))
                            ? r_count + 1'b1 : r_count;
                        n_k = (r_cfg > gkc_pkg::CFG_W'(gkc_pkg::MAX_CENTERS))
                            ? gkc_pkg::CNT_W'(gkc_pkg::MAX_CENTERS) : r_cfg;
                        n_count = '0;
                        n_round = '0;
                        n_j     = '0;
                        n_state = (n_k == '0) ? gkc_pkg::ST_OUT_RD : gkc_pkg::ST_PICK0_RD;
                    end
                end
            end
            gkc_pkg::ST_PICK0_RD: begin
                store_ctl.rd_en   = 1'b1;
                store_ctl.rd_addr = '0;
                n_state           = gkc_pkg::ST_PICK0_CAP;
            end
            gkc_pkg::ST_PICK0_CAP: begin
                n_cand_x = rd_x;
                n_cand_y = rd_y;
                n_state  = gkc_pkg::ST_CENTER;
            end
            gkc_pkg::ST_CENTER: begin
                n_valid = 1'b1;
                n_cx    = r_cand_x;
                n_cy    = r_cand_y;
                n_j     = '0;
                n_state = gkc_pkg::ST_RD;
            end
            gkc_pkg::ST_RD: begin
                store_ctl.rd_en = 1'b1;
                n_state         = gkc_pkg::ST_SQX;
            end
            gkc_pkg::ST_SQX: begin
                dist_ctl.sq_en = 1'b1;
                n_state        = gkc_pkg::ST_SQY;
            end
            gkc_pkg::ST_SQY: begin
                dist_ctl.sq_en    = 1'b1;
                dist_ctl.acc_load = 1'b1;
                sq_a              = r_cy;
                sq_b              = rd_y;
                n_state           = gkc_pkg::ST_UPD;
            end
            gkc_pkg::ST_UPD: begin
                store_ctl.d_we = closer;
                // running argmax of the lowered distances picks the next center
                if ((r_j == '0) || (new_dist > r_max)) begin
                    n_max    = new_dist;
                    n_cand_x = rd_x;
                    n_cand_y = rd_y;
                end
                if (r_j == r_n - 1'b1) begin
                    n_round = r_round + 1'b1;
                    n_j     = '0;
                    n_state = (r_round + 1'b1 == r_k) ? gkc_pkg::ST_OUT_RD
                                                     : gkc_pkg::ST_CENTER;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = gkc_pkg::ST_RD;
                end
            end
            gkc_pkg::ST_OUT_RD: begin
                store_ctl.rd_en = 1'b1;
                n_state         = gkc_pkg::ST_OUT_EMIT;
            end
            gkc_pkg::ST_OUT_EMIT: begin
                n_valid = 1'b1;
                n_kind  = gkc_pkg::KIND_POINT;
                n_index = r_j[gkc_pkg::IDX_W-1:0];
                n_ox    = rd_x;
                n_oy    = rd_y;
                n_label = (r_k == '0) ? '0 : rd_label;
                n_dist  = (r_k == '0) ? gkc_pkg::DIST_ONES : rd_dist;
                n_end   = (r_j == r_n - 1'b1);
                if (r_j == r_n - 1'b1) begin
                    n_state = gkc_pkg::ST_IDLE;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = gkc_pkg::ST_OUT_RD;
                end
            end
            default: begin
                n_state = gkc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= gkc_pkg::ST_IDLE;
            r_count        <= '0;
            r_cfg          <= gkc_pkg::CFG_RESET;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            o_result_valid <= n_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n                <= n_n;
        r_k                <= n_k;
        r_round            <= n_round;
        r_j                <= n_j;
        r_cx               <= n_cx;
        r_cy               <= n_cy;
        r_cand_x           <= n_cand_x;
        r_cand_y           <= n_cand_y;
        r_max              <= n_max;
        o_item_kind        <= n_kind;
        o_item_index       <= n_index;
        o_coord_x          <= n_ox;
        o_coord_y          <= n_oy;
        o_cluster_label    <= n_label;
        o_squared_distance <= n_dist;
        o_run_end          <= n_end;
    end

endmodule

`default_nettype wire

// File: rtl/gkc_store.sv
// ----------------------------------------------------------------------------
// gkc_store
// point coordinate, best distance and label memories with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module gkc_store (
    input  wire logic                                i_clk,
    input  wire gkc_pkg::t_store_ctl                 i_ctl,
    input  wire logic signed [gkc_pkg::COORD_W-1:0]  i_pt_x,
    input  wire logic signed [gkc_pkg::COORD_W-1:0]  i_pt_y,
    input  wire logic        [gkc_pkg::DIST_W-1:0]   i_dist,
    input  wire logic        [gkc_pkg::LBL_W-1:0]    i_label,
    output      logic signed [gkc_pkg::COORD_W-1:0]  o_rd_x,
    output      logic signed [gkc_pkg::COORD_W-1:0]  o_rd_y,
    output      logic        [gkc_pkg::DIST_W-1:0]   o_rd_dist,
    output      logic        [gkc_pkg::LBL_W-1:0]    o_rd_label
);

    logic signed [gkc_pkg::COORD_W-1:0] r_x_mem   [gkc_pkg::MAX_POINTS];
    logic signed [gkc_pkg::COORD_W-1:0] r_y_mem   [gkc_pkg::MAX_POINTS];
    logic        [gkc_pkg::DIST_W-1:0]  r_d_mem   [gkc_pkg::MAX_POINTS];
    logic        [gkc_pkg::LBL_W-1:0]   r_lbl_mem [gkc_pkg::MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.pt_we) begin
            r_x_mem[i_ctl.pt_addr] <= i_pt_x;
            r_y_mem[i_ctl.pt_addr] <= i_pt_y;
        end
        if (i_ctl.d_we) begin
            r_d_mem[i_ctl.rd_addr]   <= i_dist;
            r_lbl_mem[i_ctl.rd_addr] <= i_label;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_x     <= r_x_mem[i_ctl.rd_addr];
            o_rd_y     <= r_y_mem[i_ctl.rd_addr];
            o_rd_dist  <= r_d_mem[i_ctl.rd_addr];
            o_rd_label <= r_lbl_mem[i_ctl.rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/gkc_dist_unit.sv
// ----------------------------------------------------------------------------
// gkc_dist_unit
// shared squarer: one coordinate difference squared per cycle while sq_en is high, then summed
// ----------------------------------------------------------------------------
`default_nettype none

module gkc_dist_unit (
    input  wire logic                                i_clk,
    input  wire gkc_pkg::t_dist_ctl                  i_ctl,
    input  wire logic signed [gkc_pkg::COORD_W-1:0]  i_a,
    input  wire logic signed [gkc_pkg::COORD_W-1:0]  i_b,
    output      logic        [gkc_pkg::DIST_W-1:0]   o_sum
);

    logic signed [gkc_pkg::COORD_W:0]     diff;
    logic signed [2*gkc_pkg::COORD_W+1:0] sq;
    logic        [gkc_pkg::PROD_W-1:0]    r_prod;
    logic        [gkc_pkg::PROD_W-1:0]    r_acc;

    assign diff = {i_a[gkc_pkg::COORD_W-1], i_a} - {i_b[gkc_pkg::COORD_W-1], i_b};
    assign sq   = diff * diff;

    always_ff @(posedge i_clk) begin
        if (i_ctl.sq_en) begin
            r_prod <= sq[gkc_pkg::PROD_W-1:0];
        end
        // first square parks in the accumulator while the second is formed
        if (i_ctl.acc_load) begin
            r_acc <= r_prod;
        end
    end

    assign o_sum = {1'b0, r_acc} + {1'b0, r_prod};

endmodule

`default_nettype wire
